### sv/mie_pkg.sv
package mie_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_FINISH
    } t_state;

endpackage

### sv/mie_div.sv
module mie_div
    import mie_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    input  logic [WIDTH+1:0] i_coef,
    output logic             o_done,
    output logic [WIDTH-1:0] o_rem,
    output logic [WIDTH+1:0] o_prod
);

    // One quotient bit per cycle, most significant first. The product of the
    // quotient and the coefficient is built alongside by shift and add.
    localparam int CW   = WIDTH + 2;
    localparam int CNTW = $clog2(WIDTH);

    logic            r_run;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_rem;
    logic [CW-1:0]    r_prod;

    logic [WIDTH:0]   rem_sh;
    logic             ge;
    logic [WIDTH:0]   rem_sub;
    logic [WIDTH-1:0] n_rem;
    logic [CW-1:0]    n_prod;

    always_comb begin
        rem_sh  = {r_rem, r_quo[WIDTH-1]};
        ge      = (rem_sh >= {1'b0, i_divisor});
        rem_sub = rem_sh - {1'b0, i_divisor};
        n_rem   = ge ? rem_sub[WIDTH-1:0] : rem_sh[WIDTH-1:0];
        n_prod  = {r_prod[CW-2:0], 1'b0} + (ge ? i_coef : CW'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNTW'(WIDTH - 1);
            end else if (r_run) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_prod <= '0;
        end else if (r_run) begin
            r_quo  <= {r_quo[WIDTH-2:0], 1'b0};
            r_rem  <= n_rem;
            r_prod <= n_prod;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
    assign o_prod = r_prod;

endmodule

### sv/modular_inverse_euclid.sv
// Channel   Signals                            Transfer
// input     start, busy, i_value, i_modulus    start high while busy low
// result    o_valid, o_inverse, o_invertible   o_valid high for one cycle
//
// Each Euclid step runs one bit-serial division in mie_div, sequenced by
// the check and divide states, and an item takes at most about 1.5 * WIDTH
// steps.
// Reset is synchronous and active low; it returns the block to idle.
// The receiver cannot stall, so a result is always taken in its cycle.
module modular_inverse_euclid
    import mie_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [WIDTH-1:0] i_value,
    input  logic [WIDTH-1:0] i_modulus,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_inverse,
    output logic             o_invertible
);

    localparam int CW = WIDTH + 2;

    t_state r_state;
    t_state n_state;

    logic [WIDTH-1:0] r_r;
    logic [WIDTH-1:0] r_nr;
    logic [WIDTH-1:0] r_n;
    logic [CW-1:0]    r_t;
    logic [CW-1:0]    r_nt;
    logic             r_valid;
    logic [WIDTH-1:0] r_inverse;
    logic             r_invertible;

    logic             load;
    logic             div_start;
    logic             step_done;
    logic             finish;
    logic             div_done;
    logic [WIDTH-1:0] div_rem;
    logic [CW-1:0]    div_prod;
    logic [CW-1:0]    t_fix;

    mie_div #(
        .WIDTH(WIDTH)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(r_r),
        .i_divisor (r_nr),
        .i_coef    (r_nt),
        .o_done    (div_done),
        .o_rem     (div_rem),
        .o_prod    (div_prod)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = (r_nr == '0) ? S_FINISH : S_DIV;
            end
            S_DIV: begin
                if (div_done) n_state = S_CHECK;
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        load      = 1'b0;
        div_start = 1'b0;
        step_done = 1'b0;
        finish    = 1'b0;
        unique case (r_state)
            S_IDLE:   load      = start;
            S_CHECK:  div_start = (r_nr != '0);
            S_DIV:    step_done = div_done;
            S_FINISH: finish    = 1'b1;
            default: begin
                load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= finish;
        end
    end

    assign t_fix = r_t[CW-1] ? (r_t + {2'b00, r_n}) : r_t;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_r  <= i_modulus;
            r_nr <= i_value;
            r_n  <= i_modulus;
            r_t  <= '0;
            r_nt <= CW'(1);
        end else if (step_done) begin
            r_r  <= r_nr;
            r_nr <= div_rem;
            r_t  <= r_nt;
            r_nt <= r_t - div_prod;
        end
        if (finish) begin
            if (r_r == WIDTH'(1)) begin
                r_inverse    <= t_fix[WIDTH-1:0];
                r_invertible <= 1'b1;
            end else begin
                r_inverse    <= '0;
                r_invertible <= 1'b0;
            end
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_inverse    = r_inverse;
    assign o_invertible = r_invertible;

endmodule
